/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertions, clocked on clk; only VSS_ASSERT is off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge while rst_n is high.
`define VSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define VSS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/vss_pkg.sv */
// ----------------------------------------------------------------------------
// View similarity score package
// Widths, constants, register indexes and stage types of the scorer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vss_pkg;

  localparam int POS_WIDTH = 24;
  localparam int DIFF_W    = POS_WIDTH + 1;
  localparam int ABS_W     = 34;
  localparam int CFG_W     = 24;
  localparam int IDX_W     = 3;
  localparam int DIR_W     = 16;
  localparam int SQ_W      = 59;
  localparam int P_W       = 59;
  localparam int DOT_W     = 34;
  localparam int NRM_W     = 32;
  localparam int PROD_W    = 64;
  localparam int S_W       = 32;
  localparam int NUM_W     = 57;
  localparam int Q_W       = 24;
  localparam int DQ_W      = 24;
  localparam int SIM_W     = 50;

  localparam int SQ_STAGES  = 16;
  localparam int DIV_STAGES = 12;
  localparam int LATENCY    = 4 + SQ_STAGES + 1 + DIV_STAGES + 3;

  localparam logic [SQ_W-1:0]  D2_CAP   = SQ_W'(1) << 58;
  localparam logic [P_W-1:0]   HALF_Q24 = P_W'(1) << 23;
  localparam logic [DQ_W-1:0]  DQ_ONE   = DQ_W'(1) << 16;
  localparam logic [DQ_W-1:0]  DQ_DEGEN = DQ_W'(101) << 16;
  localparam logic [SIM_W-1:0] SIM_MAX  = {SIM_W{1'b1}};

  localparam logic [IDX_W-1:0] CFG_QPOS_X = 3'd0;
  localparam logic [IDX_W-1:0] CFG_QPOS_Y = 3'd1;
  localparam logic [IDX_W-1:0] CFG_QPOS_Z = 3'd2;
  localparam logic [IDX_W-1:0] CFG_QDIR_X = 3'd3;
  localparam logic [IDX_W-1:0] CFG_QDIR_Y = 3'd4;
  localparam logic [IDX_W-1:0] CFG_QDIR_Z = 3'd5;

  typedef struct packed {
    logic [PROD_W-1:0]       n;
    logic [PROD_W-1:0]       res;
    logic signed [DOT_W-1:0] dot;
    logic [P_W-1:0]          p;
    logic                    degen;
  } sq_stage_t;

  typedef struct packed {
    logic [NUM_W-1:0] r;
    logic [Q_W-1:0]   q;
    logic [S_W-1:0]   s;
    logic [P_W-1:0]   p;
    logic             degen;
  } div_stage_t;

endpackage

/* rtl/core/view_similarity_score.sv */
// ----------------------------------------------------------------------------
// View similarity score
// Pipelined scorer of a stored camera view against the configured query view.
// ----------------------------------------------------------------------------
// Channel   Ports                                  Handshake
// input     in_view_pos_*, in_view_dir_*           start high, busy low
// result    out_similarity, out_dir_degenerate     out_strobe, one cycle
// config    cfg_idx, cfg_data                      cfg_we
//
// One request enters every cycle; its result passes through registered stages
// s1, s2, s3, the square root, the divider, ms, mp and the output register.
// The latency is set by the square root (16 stages) and divider (12 stages).
// Reset is synchronous; it clears the valid bits and query regs (qdir z: 16384).
// Nothing stalls: busy stays low and the receiver always takes the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module view_similarity_score import vss_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [POS_WIDTH-1:0] in_view_pos_x,
  input  logic signed [POS_WIDTH-1:0] in_view_pos_y,
  input  logic signed [POS_WIDTH-1:0] in_view_pos_z,
  input  logic signed [DIR_W-1:0]     in_view_dir_x,
  input  logic signed [DIR_W-1:0]     in_view_dir_y,
  input  logic signed [DIR_W-1:0]     in_view_dir_z,
  output logic                        out_strobe,
  output logic [SIM_W-1:0]            out_similarity,
  output logic                        out_dir_degenerate,
  input  logic                        cfg_we,
  input  logic [IDX_W-1:0]            cfg_idx,
  input  logic [CFG_W-1:0]            cfg_data
);

  logic [POS_WIDTH-1:0] qpos_r [3];
  logic [DIR_W-1:0]     qdir_r [3];
  logic [POS_WIDTH-1:0] qpos_nxt;

  assign qpos_nxt = POS_WIDTH'({{POS_WIDTH{1'b0}}, cfg_data});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qpos_r[0] <= '0;
      qpos_r[1] <= '0;
      qpos_r[2] <= '0;
      qdir_r[0] <= '0;
      qdir_r[1] <= '0;
      qdir_r[2] <= DIR_W'(16384);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_QPOS_X: qpos_r[0] <= qpos_nxt;
        CFG_QPOS_Y: qpos_r[1] <= qpos_nxt;
        CFG_QPOS_Z: qpos_r[2] <= qpos_nxt;
        CFG_QDIR_X: qdir_r[0] <= cfg_data[DIR_W-1:0];
        CFG_QDIR_Y: qdir_r[1] <= cfg_data[DIR_W-1:0];
        CFG_QDIR_Z: qdir_r[2] <= cfg_data[DIR_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  logic [POS_WIDTH-1:0] vpos [3];
  logic [DIR_W-1:0]     vdir [3];
  assign vpos[0] = in_view_pos_x;
  assign vpos[1] = in_view_pos_y;
  assign vpos[2] = in_view_pos_z;
  assign vdir[0] = in_view_dir_x;
  assign vdir[1] = in_view_dir_y;
  assign vdir[2] = in_view_dir_z;

  logic                     s1_vld_r, s2_vld_r, s3_vld_r;
  logic [DIFF_W-1:0]        s1_diff_r [3];
  logic signed [DIR_W-1:0]  s1_a_r [3];
  logic signed [DIR_W-1:0]  s1_b_r [3];
  logic [SQ_W-1:0]          s2_sq_r [3];
  logic signed [31:0]       s2_ab_r [3];
  logic [NRM_W-1:0]         s2_aa_r [3];
  logic [NRM_W-1:0]         s2_bb_r [3];
  logic [SQ_W-1:0]          s2_sq_nxt [3];
  logic signed [31:0]       ab_w [3];
  logic signed [31:0]       aa_w [3];
  logic signed [31:0]       bb_w [3];

  for (genvar k = 0; k < 3; k++) begin : g_lane
    logic [DIFF_W-1:0] ad;
    logic [ABS_W-1:0]  ax;
    assign ad = s1_diff_r[k][DIFF_W-1] ? (~s1_diff_r[k] + 1'b1) : s1_diff_r[k];
    assign ax = ABS_W'(ad);
    assign s2_sq_nxt[k] = (ax[ABS_W-1:29] != '0) ? D2_CAP
                        : SQ_W'(ax[28:0] * ax[28:0]);
    assign ab_w[k] = s1_a_r[k] * s1_b_r[k];
    assign aa_w[k] = s1_a_r[k] * s1_a_r[k];
    assign bb_w[k] = s1_b_r[k] * s1_b_r[k];

    always_ff @(posedge clk) begin
      s1_diff_r[k] <= {qpos_r[k][POS_WIDTH-1], qpos_r[k]}
                    - {vpos[k][POS_WIDTH-1], vpos[k]};
      s1_a_r[k]    <= vdir[k];
      s1_b_r[k]    <= qdir_r[k];
      s2_sq_r[k]   <= s2_sq_nxt[k];
      s2_ab_r[k]   <= ab_w[k];
      s2_aa_r[k]   <= NRM_W'(aa_w[k]);
      s2_bb_r[k]   <= NRM_W'(bb_w[k]);
    end
  end

  logic [SQ_W+1:0]         d2_sum;
  logic [P_W-1:0]          d2_cap;
  logic [P_W-1:0]          s3_p_r;
  logic signed [DOT_W-1:0] s3_dot_r;
  logic [NRM_W-1:0]        s3_na_r, s3_nb_r;
  logic                    s3_degen_r;
  logic [NRM_W-1:0]        na_w, nb_w;

  assign d2_sum = (SQ_W+2)'(s2_sq_r[0]) + (SQ_W+2)'(s2_sq_r[1]) + (SQ_W+2)'(s2_sq_r[2]);
  assign d2_cap = (d2_sum > (SQ_W+2)'(D2_CAP)) ? D2_CAP : d2_sum[P_W-1:0];
  assign na_w   = s2_aa_r[0] + s2_aa_r[1] + s2_aa_r[2];
  assign nb_w   = s2_bb_r[0] + s2_bb_r[1] + s2_bb_r[2];

  always_ff @(posedge clk) begin
    s3_p_r     <= ((d2_cap > HALF_Q24) ? d2_cap : HALF_Q24) + HALF_Q24;
    s3_dot_r   <= DOT_W'(s2_ab_r[0]) + DOT_W'(s2_ab_r[1]) + DOT_W'(s2_ab_r[2]);
    s3_na_r    <= na_w;
    s3_nb_r    <= nb_w;
    s3_degen_r <= (na_w == '0) || (nb_w == '0);
  end

  sq_stage_t  sq_r  [SQ_STAGES+1];
  logic       sq_vld_r [SQ_STAGES+1];
  div_stage_t dv_r  [DIV_STAGES+1];
  logic       dv_vld_r [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    sq_r[0].n     <= PROD_W'(s3_na_r) * PROD_W'(s3_nb_r);
    sq_r[0].res   <= '0;
    sq_r[0].dot   <= s3_dot_r;
    sq_r[0].p     <= s3_p_r;
    sq_r[0].degen <= s3_degen_r;
  end

  for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sqrt
    logic [PROD_W-1:0] n_w [3];
    logic [PROD_W-1:0] r_w [3];
    assign n_w[0] = sq_r[j].n;
    assign r_w[0] = sq_r[j].res;
    for (genvar t = 0; t < 2; t++) begin : g_it
      localparam int SH = 62 - 2 * (2 * j + t);
      logic [PROD_W-1:0] trial;
      logic              take;
      assign trial = r_w[t] + (PROD_W'(1) << SH);
      assign take  = n_w[t] >= trial;
      assign n_w[t+1] = take ? (n_w[t] - trial) : n_w[t];
      assign r_w[t+1] = take ? ((r_w[t] >> 1) + (PROD_W'(1) << SH)) : (r_w[t] >> 1);
    end
    always_ff @(posedge clk) begin
      sq_r[j+1].n     <= n_w[2];
      sq_r[j+1].res   <= r_w[2];
      sq_r[j+1].dot   <= sq_r[j].dot;
      sq_r[j+1].p     <= sq_r[j].p;
      sq_r[j+1].degen <= sq_r[j].degen;
    end
  end

  logic [S_W-1:0]   s_w;
  logic [DOT_W-1:0] diffc;
  logic [39:0]      dc100;

  assign s_w   = sq_r[SQ_STAGES].res[S_W-1:0];
  assign diffc = DOT_W'({2'b00, s_w}) - sq_r[SQ_STAGES].dot;
  assign dc100 = (40'(diffc[32:0]) << 6) + (40'(diffc[32:0]) << 5)
               + (40'(diffc[32:0]) << 2);

  always_ff @(posedge clk) begin
    dv_r[0].r     <= (NUM_W'(dc100) << 16) + NUM_W'(s_w >> 1);
    dv_r[0].q     <= '0;
    dv_r[0].s     <= s_w;
    dv_r[0].p     <= sq_r[SQ_STAGES].p;
    dv_r[0].degen <= sq_r[SQ_STAGES].degen;
  end

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    logic [NUM_W-1:0] r_w [3];
    logic [Q_W-1:0]   q_w [3];
    assign r_w[0] = dv_r[j].r;
    assign q_w[0] = dv_r[j].q;
    for (genvar t = 0; t < 2; t++) begin : g_it
      localparam int QB = Q_W - 1 - (2 * j + t);
      logic [NUM_W-1:0] dvs;
      logic             take;
      assign dvs  = NUM_W'(dv_r[j].s) << QB;
      assign take = r_w[t] >= dvs;
      assign r_w[t+1] = take ? (r_w[t] - dvs) : r_w[t];
      assign q_w[t+1] = take ? (q_w[t] | (Q_W'(1) << QB)) : q_w[t];
    end
    always_ff @(posedge clk) begin
      dv_r[j+1].r     <= r_w[2];
      dv_r[j+1].q     <= q_w[2];
      dv_r[j+1].s     <= dv_r[j].s;
      dv_r[j+1].p     <= dv_r[j].p;
      dv_r[j+1].degen <= dv_r[j].degen;
    end
  end

  logic            ms_vld_r, mp_vld_r, out_vld_r;
  logic [P_W-1:0]  ms_p_r;
  logic [DQ_W-1:0] ms_dq_r;
  logic            ms_degen_r, mp_degen_r;
  logic [50:0]     mp_hi_r;
  logic [55:0]     mp_lo_r;
  logic [59:0]     score_w;
  logic [SIM_W-1:0] sim_r;
  logic            degen_out_r;

  assign score_w = (60'(mp_hi_r) << 8) + 60'((mp_lo_r + 56'(HALF_Q24)) >> 24);

  always_ff @(posedge clk) begin
    ms_p_r      <= dv_r[DIV_STAGES].p;
    ms_dq_r     <= dv_r[DIV_STAGES].degen ? DQ_DEGEN : (DQ_ONE + dv_r[DIV_STAGES].q);
    ms_degen_r  <= dv_r[DIV_STAGES].degen;
    mp_hi_r     <= 51'(ms_p_r[P_W-1:32]) * 51'(ms_dq_r);
    mp_lo_r     <= 56'(ms_p_r[31:0]) * 56'(ms_dq_r);
    mp_degen_r  <= ms_degen_r;
    sim_r       <= (score_w > 60'(SIM_MAX)) ? SIM_MAX : score_w[SIM_W-1:0];
    degen_out_r <= mp_degen_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      ms_vld_r  <= 1'b0;
      mp_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      for (int i = 0; i <= SQ_STAGES; i++) sq_vld_r[i] <= 1'b0;
      for (int i = 0; i <= DIV_STAGES; i++) dv_vld_r[i] <= 1'b0;
    end else begin
      s1_vld_r    <= accept;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r;
      sq_vld_r[0] <= s3_vld_r;
      for (int i = 0; i < SQ_STAGES; i++) sq_vld_r[i+1] <= sq_vld_r[i];
      dv_vld_r[0] <= sq_vld_r[SQ_STAGES];
      for (int i = 0; i < DIV_STAGES; i++) dv_vld_r[i+1] <= dv_vld_r[i];
      ms_vld_r    <= dv_vld_r[DIV_STAGES];
      mp_vld_r    <= ms_vld_r;
      out_vld_r   <= mp_vld_r;
    end
  end

  assign out_strobe         = out_vld_r;
  assign out_similarity     = sim_r;
  assign out_dir_degenerate = degen_out_r;

endmodule

/* rtl/core/vss_checker.sv */
// ----------------------------------------------------------------------------
// View similarity score checker
// Port-level checks on latency, score range and the degenerate flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vss_checker import vss_pkg::*; (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic signed [DIR_W-1:0]     in_view_dir_x,
  input logic signed [DIR_W-1:0]     in_view_dir_y,
  input logic signed [DIR_W-1:0]     in_view_dir_z,
  input logic                        out_strobe,
  input logic [SIM_W-1:0]            out_similarity,
  input logic                        out_dir_degenerate
);

  `VSS_ASSERT(a_latency, out_strobe |-> $past(start && !busy, LATENCY), "result without request")
  `VSS_ASSERT(a_floor, out_strobe |-> (out_similarity >= SIM_W'(65536)), "score below one")
  `VSS_ASSERT(a_degen, (out_strobe && !out_dir_degenerate) |-> $past((in_view_dir_x != 0) || (in_view_dir_y != 0) || (in_view_dir_z != 0), LATENCY), "zero direction not flagged")

endmodule

bind view_similarity_score vss_checker u_vss_checker (.*);

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// View similarity score testbench
// Streams camera view requests in random bursts against a query view that is
// reprogrammed between phases, predicts each score and degenerate flag in
// 64-bit integer arithmetic, and checks every result strobe in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import vss_pkg::*;

  localparam logic [IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [IDX_W-1:0] CFG_SPARE_7 = 3'd7;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 275;

  typedef struct {
    logic signed [POS_WIDTH-1:0] px, py, pz;
    logic signed [DIR_W-1:0]     dx, dy, dz;
  } view_t;

  typedef struct {
    logic [SIM_W-1:0] sim;
    logic             degen;
  } score_t;

  class score_board;
    logic [CFG_W-1:0] query_regs[6];
    score_t           pending_scores[$];
    int               mismatches;

    function new();
      foreach (query_regs[i]) query_regs[i] = '0;
      query_regs[CFG_QDIR_Z] = 24'd16384;
      mismatches = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx <= CFG_QPOS_Z) query_regs[idx] = data;
      else if (idx <= CFG_QDIR_Z) query_regs[idx] = {8'd0, data[15:0]};
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function void note_request(view_t v);
      longint unsigned d2, p, dq, na, nb, s, num, diffc, ph, pl, score, mag;
      longint dot, diff, a, b;
      longint vpos[3], vdir[3];
      score_t e;
      vpos = '{longint'(v.px), longint'(v.py), longint'(v.pz)};
      vdir = '{longint'(v.dx), longint'(v.dy), longint'(v.dz)};
      d2 = 0; na = 0; nb = 0; dot = 0;
      for (int i = 0; i < 3; i++) begin
        diff = longint'($signed(query_regs[i][POS_WIDTH-1:0])) - vpos[i];
        mag = (diff < 0) ? longint'(-diff) : diff;
        d2 += (mag >= (64'd1 << 29)) ? 64'(D2_CAP) : mag * mag;
        if (d2 > 64'(D2_CAP)) d2 = 64'(D2_CAP);
      end
      p = ((d2 > 64'(HALF_Q24)) ? d2 : 64'(HALF_Q24)) + 64'(HALF_Q24);
      for (int i = 0; i < 3; i++) begin
        a = vdir[i];
        b = longint'($signed(query_regs[3 + i][DIR_W-1:0]));
        dot += a * b;
        na += a * a;
        nb += b * b;
      end
      e.degen = (na == 0) || (nb == 0);
      if (e.degen) begin
        dq = 64'(DQ_DEGEN);
      end else begin
        s = int_sqrt(na * nb);
        diffc = longint'(s) - dot;
        num = diffc * 64'd6553600 + (s >> 1);
        dq = 64'd65536 + num / s;
      end
      ph = p >> 32;
      pl = p & 64'hFFFF_FFFF;
      score = ((ph * dq) << 8) + ((pl * dq + 64'(HALF_Q24)) >> 24);
      if (score > 64'(SIM_MAX)) score = 64'(SIM_MAX);
      e.sim = score[SIM_W-1:0];
      pending_scores.push_back(e);
    endfunction

    function void check_result(logic [SIM_W-1:0] sim, logic degen);
      score_t e;
      if (pending_scores.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: sim=%0d degen=%0b", sim, degen);
        return;
      end
      e = pending_scores.pop_front();
      if (sim !== e.sim || degen !== e.degen) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected sim=%0d degen=%0b, actual sim=%0d degen=%0b",
                   e.sim, e.degen, sim, degen);
      end
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic signed [POS_WIDTH-1:0] in_view_pos_x = '0;
  logic signed [POS_WIDTH-1:0] in_view_pos_y = '0;
  logic signed [POS_WIDTH-1:0] in_view_pos_z = '0;
  logic signed [DIR_W-1:0]     in_view_dir_x = '0;
  logic signed [DIR_W-1:0]     in_view_dir_y = '0;
  logic signed [DIR_W-1:0]     in_view_dir_z = '0;
  logic                        out_strobe;
  logic [SIM_W-1:0]            out_similarity;
  logic                        out_dir_degenerate;
  logic                        cfg_we = 1'b0;
  logic [IDX_W-1:0]            cfg_idx = '0;
  logic [CFG_W-1:0]            cfg_data = '0;

  score_board sb = new();
  int burst_left = 0;

  view_similarity_score u_dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("view_similarity_score regression: fail");
    $finish;
  end

  always @(negedge clk) begin
    if (rst_n && out_strobe) sb.check_result(out_similarity, out_dir_degenerate);
  end

  function automatic view_t mk_view(int px, int py, int pz, int dx, int dy, int dz);
    view_t v;
    v.px = POS_WIDTH'(px); v.py = POS_WIDTH'(py); v.pz = POS_WIDTH'(pz);
    v.dx = DIR_W'(dx); v.dy = DIR_W'(dy); v.dz = DIR_W'(dz);
    return v;
  endfunction

  function automatic logic [DIR_W-1:0] rand_dir();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return DIR_W'($urandom_range(0, 8) - 4);
      2: return DIR_W'($urandom_range(0, 512) - 256);
      default: return DIR_W'($urandom);
    endcase
  endfunction

  function automatic view_t rand_view();
    view_t v;
    logic [POS_WIDTH-1:0] off[3];
    int spread;
    spread = (1 << $urandom_range(4, 20));
    foreach (off[i]) off[i] = POS_WIDTH'($urandom_range(0, 2 * spread) - spread);
    if ($urandom_range(0, 2) == 0) begin
      v.px = POS_WIDTH'($urandom); v.py = POS_WIDTH'($urandom); v.pz = POS_WIDTH'($urandom);
    end else begin
      v.px = sb.query_regs[CFG_QPOS_X][POS_WIDTH-1:0] + off[0];
      v.py = sb.query_regs[CFG_QPOS_Y][POS_WIDTH-1:0] + off[1];
      v.pz = sb.query_regs[CFG_QPOS_Z][POS_WIDTH-1:0] + off[2];
    end
    v.dx = rand_dir(); v.dy = rand_dir(); v.dz = rand_dir();
    return v;
  endfunction

  task automatic send_view(view_t v);
    start <= 1'b1;
    in_view_pos_x <= v.px; in_view_pos_y <= v.py; in_view_pos_z <= v.pz;
    in_view_dir_x <= v.dx; in_view_dir_y <= v.dy; in_view_dir_z <= v.dz;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    sb.note_request(v);
  endtask

  task automatic hold_off(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic send_burst_view(view_t v);
    if (burst_left == 0) begin
      hold_off(($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 5));
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 30);
    end
    burst_left--;
    send_view(v);
  endtask

  task automatic drain();
    hold_off(1);
    while (sb.pending_scores.size() > 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic program_query(int phase);
    logic [CFG_W-1:0] vals[6];
    case (phase)
      0: vals = '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFF, 24'h7FFF, 24'h7FFF};
      1: vals = '{24'h800000, 24'h800000, 24'h800000, 24'h8000, 24'h8000, 24'h8000};
      2: vals = '{24'h000000, 24'h001000, 24'hFFF000, 24'h0000, 24'h0000, 24'h0000};
      3: vals = '{24'h000000, 24'h000000, 24'h000000, 24'h0001, 24'h0000, 24'hFFFF};
      default: foreach (vals[i]) vals[i] = CFG_W'($urandom);
    endcase
    foreach (vals[i]) write_reg(IDX_W'(i), vals[i]);
    write_reg(CFG_SPARE_6, CFG_W'($urandom));
    write_reg(CFG_SPARE_7, CFG_W'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    view_t directed[$];
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed = '{
      mk_view(0, 0, 0, 0, 0, 1),
      mk_view(0, 0, 0, 0, 0, -1),
      mk_view(0, 0, 0, 0, 0, 0),
      mk_view(2048, 2048, 0, 0, 0, 300),
      mk_view(4096, 0, 0, 1, 0, 0),
      mk_view(8388607, 8388607, 8388607, 32767, 32767, 32767),
      mk_view(-8388608, -8388608, -8388608, -32768, -32768, -32768),
      mk_view(8388607, -8388608, 0, -32768, 0, 0),
      mk_view(-4096, 4096, -4096, 0, -32768, -32768),
      mk_view(1, -1, 1, 32767, -32768, 16384),
      mk_view(100000, 0, -100000, 5, -7, 0),
      mk_view(0, 0, 4096, 0, 1, 1)
    };
    foreach (directed[i]) send_view(directed[i]);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      program_query(ph);
      if (ph == 2) begin
        send_view(mk_view(0, 4096, -4096, 7, 8, 9));
        send_view(mk_view(0, 0, 0, 0, 0, 0));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) send_burst_view(rand_view());
    end

    drain();
    if (sb.mismatches == 0 && sb.pending_scores.size() == 0) begin
      $display("view_similarity_score regression: pass");
    end else begin
      $display("view_similarity_score regression: fail");
    end
    $finish;
  end

endmodule
